// ----- hw/rtl/dls_pkg.sv -----
// Shared types, codes and fp32 helpers for the dynamic loss scaler.
`default_nettype none
package dls_pkg;

  localparam logic [1:0] CMD_UNSCALE = 2'd0;
  localparam logic [1:0] CMD_SCALE   = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [1:0] REG_BASE_SCALE = 2'd0;
  localparam logic [1:0] REG_GROWTH     = 2'd1;
  localparam logic [1:0] REG_BACKOFF    = 2'd2;
  localparam logic [1:0] REG_PERIOD     = 2'd3;

  localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
  localparam logic [31:0] ONE_F      = 32'h3F80_0000;
  localparam logic [31:0] BASE_SCALE = 32'h4780_0000;
  localparam logic [31:0] INIT_GROW  = 32'h4000_0000;
  localparam logic [31:0] INIT_BACK  = 32'h3F00_0000;
  localparam logic [15:0] INIT_PER   = 16'd2000;
  localparam logic [31:0] INIT_INV   = 32'h3780_0000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] val;
  } item_t;

  function automatic logic is_nonfinite(input logic [31:0] b);
    is_nonfinite = (b[30:23] == 8'hFF);
  endfunction

  // Unpack: significand with hidden bit, effective exponent.
  function automatic logic [23:0] sig_of(input logic [31:0] b);
    sig_of = {(b[30:23] != 8'd0), b[22:0]};
  endfunction

  function automatic logic signed [9:0] exp_of(input logic [31:0] b);
    exp_of = (b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, b[30:23]});
  endfunction

  // Round a positive magnitude given as 27-bit value m (bit 26 = leading one
  // position for exponent e, low bits guard/round and a sticky flag).
  // Value = m * 2^(e - 127 - 26). Handles subnormal and overflow.
  function automatic logic [31:0] round_pack(input logic sgn,
                                              input logic signed [11:0] e,
                                              input logic [26:0] m,
                                              input logic stk);
    logic [26:0] mm;
    logic        st;
    logic [11:0] sh;
    logic [24:0] r;
    logic        lsb, g, rs;
    logic signed [11:0] ee;
    mm = m;
    st = stk;
    ee = e;
    if (ee < 12'sd1) begin
      sh = 12'(12'sd1 - ee);
      if (sh > 12'd27) begin
        st = st | (|mm);
        mm = '0;
      end else begin
        st = st | (|(mm & ~(27'h7FF_FFFF << sh)));
        mm = mm >> sh;
      end
      ee = 12'sd0;
    end
    lsb = mm[3];
    g   = mm[2];
    rs  = mm[1] | mm[0] | st;
    r   = {1'b0, mm[26:3]} + 25'(g & (rs | lsb));
    if (r[24]) begin
      r  = r >> 1;
      ee = ee + 12'sd1;
    end else if (ee == 12'sd0 && r[23]) begin
      ee = 12'sd1;
    end
    if (ee >= 12'sd255) round_pack = {sgn, 8'hFF, 23'd0};
    else round_pack = {sgn, ee[7:0], r[22:0]};
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/dls_fmul.sv -----
// Two-stage fp32 multiplier, round to nearest even, canonical NaN.
`default_nettype none
module dls_fmul (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      p
);
  // Stage 1: significand product and specials.
  logic [47:0]        prod;
  logic signed [11:0] pexp;
  logic               psgn, pspec;
  logic [31:0]        pspec_val;

  logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  always_comb begin
    a_nan  = dls_pkg::is_nonfinite(a) && (a[22:0] != 0);
    b_nan  = dls_pkg::is_nonfinite(b) && (b[22:0] != 0);
    a_inf  = dls_pkg::is_nonfinite(a) && (a[22:0] == 0);
    b_inf  = dls_pkg::is_nonfinite(b) && (b[22:0] == 0);
    a_zero = a[30:0] == 0;
    b_zero = b[30:0] == 0;
    sgn    = a[31] ^ b[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= dls_pkg::sig_of(a) * dls_pkg::sig_of(b);
      pexp  <= 12'(dls_pkg::exp_of(a)) + 12'(dls_pkg::exp_of(b)) - 12'sd126;
      psgn  <= sgn;
      pspec <= a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
      if (a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero))
        pspec_val <= dls_pkg::CANON_NAN;
      else if (a_inf | b_inf)
        pspec_val <= {sgn, 8'hFF, 23'd0};
      else
        pspec_val <= {sgn, 31'd0};
    end
  end

  // Stage 2: normalize (leading-zero count over product), round.
  logic [5:0]         lz;
  logic [47:0]        nrm;
  logic signed [11:0] ne;
  always_comb begin
    lz = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod[i]) lz = 6'(47 - i);
    end
    nrm = prod << lz;
    ne  = pexp - 12'(lz);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pspec) p <= pspec_val;
      else p <= dls_pkg::round_pack(psgn, ne, nrm[47:21], |nrm[20:0]);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dls_frecip.sv -----
// Bit-serial fp32 reciprocal, one quotient bit per cycle.
`default_nettype none
module dls_frecip (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] a,
  output logic             busy,
  output logic             done,
  output logic [31:0]      q
);
  localparam int QBITS = 27;
  logic [24:0]        rem;
  logic [23:0]        den;
  logic [26:0]        quo;
  logic [4:0]         cnt;
  logic signed [11:0] qexp;
  logic               qsgn;
  logic               rnd;

  logic [23:0] sa;
  logic [4:0]  lz;
  logic [23:0] dn;
  logic [24:0] diff;
  always_comb begin
    sa = dls_pkg::sig_of(a);
    lz = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (sa[i]) lz = 5'(23 - i);
    end
    dn   = sa << lz;
    diff = rem - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      rnd  <= 1'b0;
    end else begin
      if (start) begin
        if (a[30:0] == 0) begin
          q    <= {a[31], 8'hFF, 23'd0};
          done <= 1'b1;
        end else if (dls_pkg::is_nonfinite(a)) begin
          q    <= (a[22:0] != 0) ? dls_pkg::CANON_NAN : {a[31], 31'd0};
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          done <= 1'b0;
          rem  <= 25'h080_0000;
          den  <= dn;
          quo  <= '0;
          cnt  <= 5'(QBITS - 1);
          qsgn <= a[31];
          // 1/(m*2^(ea-127)): leading quotient bit weight 2^(127-ea)
          qexp <= 12'sd254 - (12'(dls_pkg::exp_of(a)) - 12'(lz));
        end
      end else if (rnd) begin
        // quotient in [0.5,2): normalize one step then round
        rnd  <= 1'b0;
        busy <= 1'b0;
        done <= 1'b1;
        if (quo[26])
          q <= dls_pkg::round_pack(qsgn, qexp, quo, rem != 0);
        else
          q <= dls_pkg::round_pack(qsgn, qexp - 12'sd1, {quo[25:0], 1'b0}, rem != 0);
      end else if (busy) begin
        done <= 1'b0;
        if (!diff[24]) begin
          quo <= {quo[25:0], 1'b1};
          rem <= {diff[23:0], 1'b0};
        end else begin
          quo <= {quo[25:0], 1'b0};
          rem <= {rem[23:0], 1'b0};
        end
        if (cnt == 0) rnd <= 1'b1;
        else cnt <= cnt - 5'd1;
      end else begin
        done <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dls_front.sv -----
// Input side: two-entry command queue between accept and execute.
`default_nettype none
module dls_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dls_pkg::item_t in_item,
  output logic                q_valid,
  input  wire logic           q_pop,
  output dls_pkg::item_t      q_item
);
  dls_pkg::item_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign in_ready = cnt != 2'd2;
  assign q_valid  = cnt != 2'd0;
  assign q_item   = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/dynamic_loss_scaler.sv -----
// Top level of the dynamic loss scaler: config registers, queue, executor.
//
//  Channel  | Signals                         | Contents
//  ---------+---------------------------------+------------------------------
//  input    | s_axis_tvalid/tready/tdata/tuser| tdata operand_value, tuser command
//  output   | m_axis_tvalid/tready/tdata/tuser| tdata result_value, tuser overflow_seen
//  config   | cfg_valid/cfg_ready/index/data  | register index 0..3, 32-bit data
//
// Gradient and loss words pass through the two multiplier stages and the
// output state before valid rises; the executor handles one word at a time,
// so it pops a new word only once the last result has been handed over. An
// update runs the scale multiply, starts the reciprocal, computes its quotient
// bits, rounds, loads the inverse and then raises valid. An unused command
// raises valid in the cycle after the pop. An initial-scale write starts the
// reciprocal too and holds off words and config until the inverse has been
// loaded; the reset inverse is a constant. Reset is synchronous and clears
// all control.
// A full output register stalls the executor; the queue still takes words.
`default_nettype none
module dynamic_loss_scaler #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] operand_value
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] result_value
  output logic             m_axis_tuser,   // [0] overflow_seen
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RCP   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [31:0] growth_multiplier, backoff_multiplier, working_scale, inverse_scale;
  logic [15:0] growth_period;
  logic [COUNT_BITS-1:0] clean_count;
  logic        overflow_flag;
  logic [2:0]  state;
  logic [1:0]  mcnt;
  logic [1:0]  cur_cmd;
  logic        cur_flag;
  logic        cur_apply;

  dls_pkg::item_t in_item, q_item;
  logic q_valid, q_pop;
  assign in_item = '{cmd: s_axis_tuser, val: s_axis_tdata};

  dls_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_item(in_item), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  // Multiplier operand select.
  logic [31:0] ma, mb, mp;
  logic        grow;
  logic [COUNT_BITS-1:0] cnt_inc;
  always_comb begin
    cnt_inc = (clean_count < COUNT_MAX) ? clean_count + 1'b1 : clean_count;
    grow = (32'(cnt_inc) >= 32'(growth_period));
    ma = q_item.val;
    mb = inverse_scale;
    case (q_item.cmd)
      dls_pkg::CMD_UNSCALE: mb = inverse_scale;
      dls_pkg::CMD_SCALE:   mb = working_scale;
      dls_pkg::CMD_UPDATE: begin
        ma = working_scale;
        mb = overflow_flag ? backoff_multiplier : (grow ? growth_multiplier : dls_pkg::ONE_F);
      end
      default: mb = inverse_scale;
    endcase
  end

  dls_fmul u_mul (.clk(clk), .en(1'b1), .a(ma), .b(mb), .p(mp));

  logic rstart, rbusy, rdone;
  logic [31:0] ra, rq;
  logic cfg_fire;
  logic rcp_pend;
  assign cfg_ready = (state == ST_IDLE) && !rbusy && !rdone && !rcp_pend;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign rstart = (state == ST_RCP) || (cfg_fire && cfg_index == dls_pkg::REG_BASE_SCALE);
  assign ra     = (state == ST_RCP) ? working_scale : cfg_data;

  dls_frecip u_rcp (.clk(clk), .rst(rst), .start(rstart), .a(ra),
                    .busy(rbusy), .done(rdone), .q(rq));

  assign q_pop = (state == ST_IDLE) && q_valid && !m_axis_tvalid && !rbusy && !rdone
                 && !rcp_pend && !cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      rcp_pend <= 1'b0;
      growth_multiplier <= dls_pkg::INIT_GROW;
      backoff_multiplier <= dls_pkg::INIT_BACK;
      growth_period <= dls_pkg::INIT_PER;
      working_scale <= dls_pkg::BASE_SCALE;
      inverse_scale <= dls_pkg::INIT_INV;
      clean_count <= '0;
      overflow_flag <= 1'b0;
      mcnt <= '0;
      cur_cmd <= dls_pkg::CMD_UNSCALE;
      cur_flag <= 1'b0;
      cur_apply <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      // a finished reciprocal is flagged in rcp_pend after done, then lands in the register
      if (rdone) rcp_pend <= 1'b1;
      if (rcp_pend) begin
        rcp_pend <= 1'b0;
        inverse_scale <= rq;
      end
      if (cfg_fire) begin
        case (cfg_index)
          dls_pkg::REG_BASE_SCALE: working_scale <= cfg_data;
          dls_pkg::REG_GROWTH:     growth_multiplier <= cfg_data;
          dls_pkg::REG_BACKOFF:    backoff_multiplier <= cfg_data;
          dls_pkg::REG_PERIOD:     growth_period <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur_cmd <= q_item.cmd;
            mcnt <= 2'd0;
            case (q_item.cmd)
              dls_pkg::CMD_UNSCALE: begin
                cur_flag <= overflow_flag | dls_pkg::is_nonfinite(q_item.val);
                overflow_flag <= overflow_flag | dls_pkg::is_nonfinite(q_item.val);
                state <= ST_MUL;
              end
              dls_pkg::CMD_SCALE: begin
                cur_flag <= overflow_flag;
                state <= ST_MUL;
              end
              dls_pkg::CMD_UPDATE: begin
                cur_flag <= overflow_flag;
                // keep the scale bits as they are when neither factor applies
                cur_apply <= overflow_flag | grow;
                if (overflow_flag) clean_count <= '0;
                else clean_count <= grow ? '0 : cnt_inc;
                overflow_flag <= 1'b0;
                state <= ST_MUL;
              end
              default: begin
                m_axis_tdata <= '0;
                m_axis_tuser <= overflow_flag;
                m_axis_tvalid <= 1'b1;
              end
            endcase
          end
        end
        ST_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd1) begin
            if (cur_cmd == dls_pkg::CMD_UPDATE) begin
              if (cur_apply) working_scale <= mp;
              state <= ST_RCP;
            end else begin
              m_axis_tdata <= mp;
              m_axis_tuser <= cur_flag;
              state <= ST_OUT;
            end
          end
        end
        ST_RCP:  state <= ST_WAIT;
        ST_WAIT: begin
          if (rcp_pend) begin
            m_axis_tdata <= working_scale;
            m_axis_tuser <= cur_flag;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- bench/dynamic_loss_scaler_tb.sv -----
// Self-checking testbench for the dynamic loss scaler: stream stimulus, fp32 predictor, checks.
`default_nettype none
module dynamic_loss_scaler_tb;

  localparam int          COUNT_BITS  = 16;
  localparam int unsigned COUNT_TOP   = (1 << COUNT_BITS) - 1;
  localparam int          IDLE_PCT    = 7;
  localparam int          DRAIN_WAIT  = 60;       // longer than one update plus hand-off
  localparam int          CYCLE_LIMIT = 1000000;
  localparam int          PHASE_WORDS = 330;

  // Predictor of the scaler: own copy of registers and state, bit-exact fp32 math.
  class scale_tracker;
    logic [31:0] grow_mul, back_mul, scale, inv;
    logic [15:0] period;
    int unsigned clean_cnt;
    bit          ovf;
    logic [32:0] pending[$];   // {overflow_seen, result_value}

    function new();
      grow_mul  = dls_pkg::INIT_GROW;
      back_mul  = dls_pkg::INIT_BACK;
      period    = dls_pkg::INIT_PER;
      scale     = dls_pkg::BASE_SCALE;
      inv       = fp_recip(dls_pkg::BASE_SCALE);
      clean_cnt = 0;
      ovf       = 0;
    endfunction

    static function bit is_nan(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 0;
    endfunction

    // Round value p * 2^x (plus sticky st) to fp32, nearest even, with subnormals.
    static function logic [31:0] fp_round(bit s, longint unsigned p, int x, bit st);
      int l, e, sh, ee;
      longint unsigned m, v;
      bit g, lost;
      l = 63;
      while (!p[l]) l--;
      e  = l + x + 127;
      sh = l - 23;
      ee = e;
      if (e < 1) begin
        sh += 1 - e;
        ee = 1;
      end
      g = 0;
      lost = st;
      if (sh <= 0) begin
        m = p << (-sh);
      end else if (sh > 60) begin
        m = 0;
        lost = 1;
      end else begin
        m = p >> sh;
        g = p[sh-1];
        if (sh > 1) lost |= (p & ((64'd1 << (sh - 1)) - 1)) != 0;
      end
      if (g && (lost || m[0])) m++;
      // Hidden bit carries into the exponent field, which covers subnormal promotion.
      v = (longint'(ee - 1) << 23) + m;
      if (v >= (64'hFF << 23)) return {s, 8'hFF, 23'd0};
      return {s, v[30:0]};
    endfunction

    static function logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      bit s;
      longint unsigned ma, mb;
      int ea, eb;
      s = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return dls_pkg::CANON_NAN;
      if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
        if (a[30:0] == 0 || b[30:0] == 0) return dls_pkg::CANON_NAN;
        return {s, 8'hFF, 23'd0};
      end
      if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
      ma = {a[30:23] != 0, a[22:0]};
      mb = {b[30:23] != 0, b[22:0]};
      ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
      return fp_round(s, ma * mb, ea + eb - 300, 0);
    endfunction

    static function logic [31:0] fp_recip(logic [31:0] a);
      longint unsigned ma, q, r;
      int ea;
      if (a[30:0] == 0) return {a[31], 8'hFF, 23'd0};
      if (is_nan(a)) return dls_pkg::CANON_NAN;
      if (a[30:23] == 8'hFF) return {a[31], 31'd0};
      ma = {a[30:23] != 0, a[22:0]};
      ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
      q  = (64'd1 << 50) / ma;
      r  = (64'd1 << 50) % ma;
      return fp_round(a[31], q, 100 - ea, r != 0);
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] d);
      case (idx)
        dls_pkg::REG_BASE_SCALE: begin
          scale = d;
          inv   = fp_recip(d);
        end
        dls_pkg::REG_GROWTH:  grow_mul = d;
        dls_pkg::REG_BACKOFF: back_mul = d;
        default:              period = d[15:0];
      endcase
    endfunction

    // Note an accepted word and queue the result it must produce.
    function void note_word(logic [1:0] cmd, logic [31:0] val);
      logic [31:0] res;
      bit flag;
      res = '0;
      case (cmd)
        dls_pkg::CMD_UNSCALE: begin
          if (val[30:23] == 8'hFF) ovf = 1;
          res  = fp_mul(val, inv);
          flag = ovf;
        end
        dls_pkg::CMD_SCALE: begin
          res  = fp_mul(val, scale);
          flag = ovf;
        end
        dls_pkg::CMD_UPDATE: begin
          flag = ovf;
          if (ovf) begin
            scale = fp_mul(scale, back_mul);
            clean_cnt = 0;
          end else begin
            if (clean_cnt < COUNT_TOP) clean_cnt++;
            if (clean_cnt >= period) begin
              scale = fp_mul(scale, grow_mul);
              clean_cnt = 0;
            end
          end
          inv = fp_recip(scale);
          ovf = 0;
          res = scale;
        end
        default: flag = ovf;
      endcase
      pending.push_back({flag, res});
    endfunction

    // Compare a result word against the oldest expectation; why holds the reason.
    function bit check_word(logic [31:0] d, logic f, output string why);
      logic [32:0] exp_w;
      why = "";
      if (pending.size() == 0) begin
        why = $sformatf("unexpected result %h/%b", d, f);
        return 0;
      end
      exp_w = pending.pop_front();
      if (d !== exp_w[31:0])
        why = $sformatf("result_value %h, want %h", d, exp_w[31:0]);
      else if (f !== exp_w[32])
        why = $sformatf("overflow_seen %b, want %b (value %h)", f, exp_w[32], d);
      return why == "";
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] operand_value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // [31:0] result_value
  logic        m_axis_tuser;        // [0] overflow_seen
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  scale_tracker tracker = new();
  int  err_count = 0;
  int  cycles = 0;
  bit  steady = 0;   // suppress idling on both sides while set

  dynamic_loss_scaler #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(string msg);
    err_count++;
    $display("mismatch @%0d: %s", cycles, msg);
  endtask

  // Timeout: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall at random, except during the steady stretch.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 0;
    else m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Check every result word that is handed over.
  always @(posedge clk) begin
    string why;
    if (!rst && m_axis_tvalid && m_axis_tready)
      if (!tracker.check_word(m_axis_tdata, m_axis_tuser, why)) report(why);
  end

  // Push one word; hold valid across back-to-back words and note it on acceptance.
  task automatic send_word(logic [1:0] cmd, logic [31:0] val);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= val;
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_word(cmd, val);
  endtask

  // Hold off until every expected word has come and the block has settled.
  task automatic drain();
    s_axis_tvalid <= 0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] d);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    tracker.write_reg(idx, d);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Operand mix: many values near unity, some raw bit patterns, some specials.
  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(99);
    if (k < 55) return {1'($urandom), 8'($urandom_range(150, 104)), 23'($urandom)};
    if (k < 85) return $urandom;
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h0000_0001 + $urandom_range(15);
      3: return 32'h7F7F_FFFF;
      4: return {1'($urandom), 8'h00, 23'($urandom)};
      5: return {1'($urandom), 8'($urandom_range(254, 230)), 23'($urandom)};
      6: return {1'($urandom), 8'($urandom_range(24, 1)), 23'($urandom)};
      default: return 32'hFF7F_FFFF;
    endcase
  endfunction

  // One iteration: random gradients and losses, occasionally a bad element, then update.
  task automatic iteration(int bad_pct);
    int n;
    n = $urandom_range(12, 1);
    for (int i = 0; i < n; i++) begin
      int k;
      k = $urandom_range(99);
      if (k < bad_pct)
        send_word(dls_pkg::CMD_UNSCALE,
                  {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'($urandom) : 23'd0)});
      else if (k < 80) send_word(dls_pkg::CMD_UNSCALE, pick_value());
      else if (k < 97) send_word(dls_pkg::CMD_SCALE, pick_value());
      else send_word(dls_pkg::CMD_NONE, $urandom);
    end
    send_word(dls_pkg::CMD_UPDATE, $urandom);
  endtask

  task automatic random_phase(int words, int bad_pct);
    for (int w = 0; w < words; w += 8) iteration(bad_pct);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: reset scale, extremes of the operand, every command, bad elements.
    send_word(dls_pkg::CMD_SCALE,   dls_pkg::ONE_F);
    send_word(dls_pkg::CMD_UNSCALE, dls_pkg::ONE_F);
    send_word(dls_pkg::CMD_UNSCALE, 32'h0000_0000);
    send_word(dls_pkg::CMD_UNSCALE, 32'h8000_0000);
    send_word(dls_pkg::CMD_UNSCALE, 32'h0000_0001);
    send_word(dls_pkg::CMD_SCALE,   32'h7F7F_FFFF);
    send_word(dls_pkg::CMD_SCALE,   32'hFFFF_FFFF);
    send_word(dls_pkg::CMD_NONE,    32'hFFFF_FFFF);
    send_word(dls_pkg::CMD_UPDATE,  32'h0000_0000);
    send_word(dls_pkg::CMD_UNSCALE, 32'h7F80_0000);
    send_word(dls_pkg::CMD_SCALE,   32'h3F80_0001);
    send_word(dls_pkg::CMD_NONE,    32'h0000_0000);
    send_word(dls_pkg::CMD_UPDATE,  32'hFFFF_FFFF);
    send_word(dls_pkg::CMD_UNSCALE, 32'hFF80_0000);
    send_word(dls_pkg::CMD_UNSCALE, 32'h7FC0_0001);
    send_word(dls_pkg::CMD_UPDATE,  32'h1234_5678);
    send_word(dls_pkg::CMD_UNSCALE, 32'h0080_0000);
    send_word(dls_pkg::CMD_UPDATE,  32'h0);

    // Growth every clean iteration, then extreme scales.
    write_reg(dls_pkg::REG_PERIOD, 32'd1);
    send_word(dls_pkg::CMD_UPDATE, 32'h0);
    send_word(dls_pkg::CMD_UPDATE, 32'h0);
    write_reg(dls_pkg::REG_BASE_SCALE, 32'h0000_0000);
    send_word(dls_pkg::CMD_UNSCALE, dls_pkg::ONE_F);
    send_word(dls_pkg::CMD_UNSCALE, 32'h0000_0000);
    send_word(dls_pkg::CMD_UPDATE, 32'h0);
    write_reg(dls_pkg::REG_BASE_SCALE, 32'h7F7F_FFFF);
    send_word(dls_pkg::CMD_UNSCALE, 32'h7F7F_FFFF);
    send_word(dls_pkg::CMD_UPDATE, 32'h0);

    // Steady stretch, after which the sender pauses until everything has come back.
    steady = 1;
    write_reg(dls_pkg::REG_GROWTH, dls_pkg::INIT_GROW);
    write_reg(dls_pkg::REG_BASE_SCALE, dls_pkg::BASE_SCALE);
    random_phase(200, 3);
    drain();
    steady = 0;

    // Settings at and near the extremes; random factors around unity.
    write_reg(dls_pkg::REG_PERIOD, 32'd3);
    write_reg(dls_pkg::REG_BACKOFF, 32'h3F00_0000);
    write_reg(dls_pkg::REG_BASE_SCALE, 32'h0000_0001);
    random_phase(PHASE_WORDS, 4);

    write_reg(dls_pkg::REG_GROWTH, {1'b0, 8'($urandom_range(140, 120)), 23'($urandom)});
    write_reg(dls_pkg::REG_BACKOFF,
              {1'($urandom), 8'($urandom_range(130, 100)), 23'($urandom)});
    write_reg(dls_pkg::REG_BASE_SCALE, 32'h7F00_0000);
    write_reg(dls_pkg::REG_PERIOD, 32'd2);
    random_phase(PHASE_WORDS, 6);

    write_reg(dls_pkg::REG_PERIOD, 32'd0);
    write_reg(dls_pkg::REG_GROWTH, 32'hFFFF_FFFF);
    write_reg(dls_pkg::REG_BACKOFF, 32'h0000_0000);
    write_reg(dls_pkg::REG_BASE_SCALE, 32'hFFFF_FFFF);
    random_phase(150, 5);

    write_reg(dls_pkg::REG_PERIOD, 32'h0000_FFFF);
    write_reg(dls_pkg::REG_GROWTH, 32'h7F80_0000);
    write_reg(dls_pkg::REG_BACKOFF, 32'h7F7F_FFFF);
    write_reg(dls_pkg::REG_BASE_SCALE, $urandom);
    random_phase(200, 3);

    write_reg(dls_pkg::REG_PERIOD, 32'($urandom_range(4, 1)));
    write_reg(dls_pkg::REG_GROWTH, 32'h4000_0000);
    write_reg(dls_pkg::REG_BACKOFF, 32'h8000_0001);
    write_reg(dls_pkg::REG_BASE_SCALE,
              {1'b0, 8'($urandom_range(200, 60)), 23'($urandom)});
    random_phase(PHASE_WORDS, 2);

    write_reg(dls_pkg::REG_BASE_SCALE, {1'b1, 8'h00, 23'($urandom)});
    write_reg(dls_pkg::REG_GROWTH, $urandom);
    write_reg(dls_pkg::REG_BACKOFF, $urandom);
    random_phase(200, 5);

    drain();
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
